>>> design/lcs_pkg.sv
// shared types and constants for the led cube layer scanner
package lcs_pkg;

  localparam int unsigned NumLayers     = 8;
  localparam int unsigned LayerW        = 3;
  localparam int unsigned RowW          = 3;
  localparam int unsigned BitW          = 3;
  localparam int unsigned AddrW         = LayerW + RowW;
  localparam int unsigned ByteW         = 8;
  localparam int unsigned OnTimeW       = 11;
  localparam int unsigned TickW         = 7;
  localparam int unsigned CfgIdxW       = 3;

  localparam logic [TickW-1:0]   TicksPerPulse = 7'd100;
  localparam logic [OnTimeW-1:0] PulseBase     = 11'd51;

  // brightness after reset, layer 7 first
  localparam logic [NumLayers-1:0][ByteW-1:0] BrightReset = {
    8'd144, 8'd80, 8'd48, 8'd32, 8'd24, 8'd20, 8'd18, 8'd17
  };

  // input item kinds
  localparam logic KindWrite = 1'b0;
  localparam logic KindTick  = 1'b1;

  typedef struct packed {
    logic               kind;
    logic [LayerW-1:0]  layer_sel;
    logic [RowW-1:0]    row_sel;
    logic [ByteW-1:0]   pixel_byte;
  } item_t;

  typedef struct packed {
    logic [ByteW-1:0]      gate_mask;
    logic [OnTimeW-1:0]    on_time;
    logic                  data_bit;
    logic [RowW+BitW-1:0]  bit_index;
    logic                  last_bit;
    logic                  tenth_second;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic wr_frame;   // store the pixel byte of the accepted item
    logic tick_load;  // latch gate, on-time, pulse and advance the layer
    logic fetch;      // read row 0 of the new layer
    logic shift;      // present one serial bit and advance the counters
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_last;  // current bit is the 64th of the layer
  } status_t;

  typedef enum logic [1:0] {
    StIdle,
    StFetch,
    StShift
  } state_e;

endpackage

>>> design/lcs_ctrl.sv
// controller state machine: accepts items and sequences the serial scan
module lcs_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             kind_i,
  input  lcs_pkg::status_t status_i,
  output lcs_pkg::cmd_t    cmd_o,
  output logic             busy_o,
  output logic             strobe_o
);

  lcs_pkg::state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lcs_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d  = state_q;
    cmd_o    = '0;
    busy_o   = 1'b1;
    strobe_o = 1'b0;
    unique case (state_q)
      lcs_pkg::StIdle: begin
        busy_o = 1'b0;
        if (start_i) begin
          if (kind_i == lcs_pkg::KindTick) begin
            cmd_o.tick_load = 1'b1;
            state_d         = lcs_pkg::StFetch;
          end else begin
            cmd_o.wr_frame = 1'b1;
          end
        end
      end
      lcs_pkg::StFetch: begin
        cmd_o.fetch = 1'b1;
        state_d     = lcs_pkg::StShift;
      end
      lcs_pkg::StShift: begin
        cmd_o.shift = 1'b1;
        strobe_o    = 1'b1;
        if (status_i.scan_last) begin
          state_d = lcs_pkg::StIdle;
        end
      end
      default: begin
        state_d = lcs_pkg::StIdle;
      end
    endcase
  end

  // scan ends only after the last bit went out
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> $past(status_i.scan_last && strobe_o))
    else $error("busy dropped before the last serial bit");

  // a fetch always follows a tick load
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.tick_load |=> cmd_o.fetch)
    else $error("tick accepted without a row fetch");

endmodule

>>> design/lcs_datapath.sv
// datapath: frame store, brightness registers, layer and pulse counters, serializer
module lcs_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lcs_pkg::cmd_t                 cmd_i,
  input  lcs_pkg::item_t                item_i,
  input  logic                          cfg_we_i,
  input  logic [lcs_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [lcs_pkg::ByteW-1:0]     cfg_data_i,
  output lcs_pkg::status_t              status_o,
  output lcs_pkg::result_t              result_o
);

  localparam int unsigned Depth = 1 << lcs_pkg::AddrW;

  // frame store memory with per-entry valid bits, unwritten entries read as zero
  logic [lcs_pkg::ByteW-1:0] mem [Depth];
  logic [Depth-1:0]          valid_q;
  logic [lcs_pkg::ByteW-1:0] rd_data_q;
  logic                      rd_valid_q;

  logic [lcs_pkg::NumLayers-1:0][lcs_pkg::ByteW-1:0] bright_q;
  logic [lcs_pkg::LayerW-1:0]  layer_q;
  logic [lcs_pkg::TickW-1:0]   tick_q, tick_d;
  logic [lcs_pkg::RowW-1:0]    row_q;
  logic [lcs_pkg::BitW-1:0]    bit_q;
  logic [lcs_pkg::ByteW-1:0]   gate_q, gate_d;
  logic [lcs_pkg::OnTimeW-1:0] on_time_q, on_time_d;
  logic                        pulse_q, pulse_d;

  logic [lcs_pkg::ByteW-1:0]   cur_bright;
  logic [lcs_pkg::OnTimeW-1:0] bright_ext;
  logic                        row_end, bit_end;
  logic                        rd_en;
  logic [lcs_pkg::AddrW-1:0]   wr_addr, rd_addr;
  logic [lcs_pkg::RowW-1:0]    rd_row;
  logic [lcs_pkg::ByteW-1:0]   row_byte;

  assign wr_addr = {item_i.layer_sel, item_i.row_sel};
  assign bit_end = (bit_q == '1);
  assign row_end = (row_q == '1);

  // next row is read on the last bit of the current one
  assign rd_en   = cmd_i.fetch || (cmd_i.shift && bit_end && !row_end);
  assign rd_row  = cmd_i.fetch ? '0 : lcs_pkg::RowW'(row_q + 1'b1);
  assign rd_addr = {layer_q, rd_row};

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_frame) begin
      mem[wr_addr] <= item_i.pixel_byte;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (cmd_i.wr_frame) begin
        valid_q[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid_q <= valid_q[rd_addr];
      end
    end
  end

  assign row_byte = rd_valid_q ? rd_data_q : '0;

  // brightness registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bright_q <= lcs_pkg::BrightReset;
    end else if (cfg_we_i) begin
      bright_q[cfg_index_i] <= cfg_data_i;
    end
  end

  // gate mask, on-time and pulse of the layer being shown
  assign cur_bright = bright_q[layer_q];
  assign bright_ext = lcs_pkg::OnTimeW'(cur_bright);

  always_comb begin
    gate_d    = '0;
    on_time_d = '0;
    if (cur_bright != '0) begin
      gate_d    = lcs_pkg::ByteW'(1) << layer_q;
      on_time_d = lcs_pkg::PulseBase + (bright_ext << 3) - bright_ext;
    end
    tick_d  = lcs_pkg::TickW'(tick_q + 1'b1);
    pulse_d = 1'b0;
    if (tick_d >= lcs_pkg::TicksPerPulse) begin
      tick_d  = '0;
      pulse_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.tick_load) begin
      gate_q    <= gate_d;
      on_time_q <= on_time_d;
      pulse_q   <= pulse_d;
    end
  end

  // layer, pulse and bit position counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      layer_q <= '0;
      tick_q  <= '0;
      row_q   <= '0;
      bit_q   <= '0;
    end else begin
      if (cmd_i.tick_load) begin
        layer_q <= lcs_pkg::LayerW'(layer_q + 1'b1);
        tick_q  <= tick_d;
      end
      if (cmd_i.fetch) begin
        row_q <= '0;
        bit_q <= '0;
      end else if (cmd_i.shift) begin
        bit_q <= lcs_pkg::BitW'(bit_q + 1'b1);
        if (bit_end) begin
          row_q <= lcs_pkg::RowW'(row_q + 1'b1);
        end
      end
    end
  end

  // result transaction, msb of each row first
  assign status_o.scan_last    = row_end && bit_end;
  assign result_o.gate_mask    = gate_q;
  assign result_o.on_time      = on_time_q;
  assign result_o.data_bit     = row_byte[~bit_q];
  assign result_o.bit_index    = {row_q, bit_q};
  assign result_o.last_bit     = row_end && bit_end;
  assign result_o.tenth_second = pulse_q;

  // pulse counter never rests at or above its wrap point
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_q < lcs_pkg::TicksPerPulse)
    else $error("tick counter out of range");

  // a dark layer has no on-time and a lit one has one gate
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.shift |-> ((gate_q == '0) == (on_time_q == '0)) && $onehot0(gate_q))
    else $error("gate mask and on-time disagree");

  // each scan starts at the first bit of row 0
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.fetch |=> (row_q == '0) && (bit_q == '0))
    else $error("scan did not start at bit zero");

endmodule

>>> design/led_cube_layer_scanner.sv
// top level of the led cube layer scanner
// a scan tick passes from the idle accept through the fetch state, which reads row 0,
//   to the shift state, which presents its bits; a frame write is stored at the accepting edge
// throughput: one frame write per cycle while not busy; a scan tick holds busy until its
//   64 bits have shifted out one per cycle, so no new item is taken before then
// reset: frame store reads zero, layer and pulse counters clear, brightness reloads
//   its defaults; results are strobed for one cycle and the receiver cannot stall
module led_cube_layer_scanner (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  lcs_pkg::item_t                item_i,
  output logic                          res_strobe_o,
  output lcs_pkg::result_t              result_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [lcs_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [lcs_pkg::ByteW-1:0]     cfg_data_i
);

  lcs_pkg::cmd_t    cmd;
  lcs_pkg::status_t status;

  // brightness registers always take a write
  assign cfg_ready_o = 1'b1;

  lcs_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .kind_i   (item_i.kind),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy),
    .strobe_o (res_strobe_o)
  );

  lcs_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .item_i      (item_i),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .status_o    (status),
    .result_o    (result_o)
  );

endmodule

>>> test/testbench.sv
// self-checking testbench for the led cube layer scanner
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned SettleCycles = 8;
  localparam int unsigned WatchLimit   = 2000;
  localparam int unsigned TickPct      = 75;
  localparam int unsigned ItemW        = $bits(lcs_pkg::item_t);
  localparam int unsigned FrameDepth   = 1 << lcs_pkg::AddrW;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         start;
  logic                         busy;
  lcs_pkg::item_t               item_i;
  logic                         res_strobe_o;
  lcs_pkg::result_t             result_o;
  logic                         cfg_valid_i;
  logic                         cfg_ready_o;
  logic [lcs_pkg::CfgIdxW-1:0]  cfg_index_i;
  logic [lcs_pkg::ByteW-1:0]    cfg_data_i;

  // shadow copy of the block state
  logic [lcs_pkg::ByteW-1:0]    bright_mdl [lcs_pkg::NumLayers];
  logic [lcs_pkg::ByteW-1:0]    frame_mdl  [FrameDepth];
  logic [lcs_pkg::LayerW-1:0]   layer_mdl;
  logic [lcs_pkg::TickW-1:0]    tick_mdl;
  lcs_pkg::result_t             scan_bits_q [$];

  int unsigned         mismatch_count;
  int unsigned         gap_pct;
  int unsigned         quiet_cycles;

  led_cube_layer_scanner u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .item_i       (item_i),
    .res_strobe_o (res_strobe_o),
    .result_o     (result_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  // 8 ns clock
  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // predict the serial bits that one accepted item produces
  function automatic void predict_scan(lcs_pkg::item_t it);
    lcs_pkg::result_t          bit_r;
    logic [lcs_pkg::ByteW-1:0] lvl;
    logic [lcs_pkg::ByteW-1:0] row_byte;
    logic [5:0]                pos;
    if (it.kind == lcs_pkg::KindWrite) begin
      frame_mdl[{it.layer_sel, it.row_sel}] = it.pixel_byte;
      return;
    end
    lvl = bright_mdl[layer_mdl];
    if (lvl != '0) begin
      bit_r.gate_mask = lcs_pkg::ByteW'(1 << layer_mdl);
      bit_r.on_time   = lcs_pkg::PulseBase + lcs_pkg::OnTimeW'(7 * lvl);
    end else begin
      bit_r.gate_mask = '0;
      bit_r.on_time   = '0;
    end
    layer_mdl = layer_mdl + 1'b1;
    // pulse counter wraps once it reaches the pulse period
    tick_mdl = tick_mdl + 1'b1;
    bit_r.tenth_second = 1'b0;
    if (tick_mdl >= lcs_pkg::TicksPerPulse) begin
      bit_r.tenth_second = 1'b1;
      tick_mdl = '0;
    end
    // next layer goes out row 0 first, msb first
    for (int idx = 0; idx < 64; idx++) begin
      pos            = 6'(idx);
      row_byte       = frame_mdl[{layer_mdl, pos[5:3]}];
      bit_r.data_bit  = row_byte[3'd7 - pos[2:0]];
      bit_r.bit_index = pos;
      bit_r.last_bit  = (idx == 63);
      scan_bits_q.push_back(bit_r);
    end
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // compare every strobed bit against the oldest prediction
  always @(posedge clk_i) begin
    lcs_pkg::result_t want;
    if (rst_ni && res_strobe_o) begin
      if (scan_bits_q.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, actual %h", $time, result_o);
        mismatch_count++;
      end else begin
        want = scan_bits_q.pop_front();
        check_field("gate_mask", 32'(want.gate_mask), 32'(result_o.gate_mask));
        check_field("on_time", 32'(want.on_time), 32'(result_o.on_time));
        check_field("data_bit", 32'(want.data_bit), 32'(result_o.data_bit));
        check_field("bit_index", 32'(want.bit_index), 32'(result_o.bit_index));
        check_field("last_bit", 32'(want.last_bit), 32'(result_o.last_bit));
        check_field("tenth_second", 32'(want.tenth_second),
                    32'(result_o.tenth_second));
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || res_strobe_o || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchLimit) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // send one item, with random idle cycles ahead of it
  task automatic send_item(input lcs_pkg::item_t it);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start  <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy);
    predict_scan(it);
  endtask

  // stop sending and wait until every predicted bit has come out
  task automatic settle_idle();
    start <= 1'b0;
    while (scan_bits_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // write all brightness registers while the block is idle
  task automatic program_brightness(
    input logic [lcs_pkg::NumLayers-1:0][lcs_pkg::ByteW-1:0] lvls);
    settle_idle();
    for (int k = 0; k < lcs_pkg::NumLayers; k++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= lcs_pkg::CfgIdxW'(k);
      cfg_data_i  <= lvls[k];
      do @(posedge clk_i); while (!cfg_ready_o);
      bright_mdl[k] = lvls[k];
    end
    cfg_valid_i <= 1'b0;
  endtask

  function automatic lcs_pkg::item_t frame_write(input int unsigned lay,
                                                 input int unsigned row,
                                                 input logic [lcs_pkg::ByteW-1:0] pix);
    lcs_pkg::item_t it;
    it.kind       = lcs_pkg::KindWrite;
    it.layer_sel  = lcs_pkg::LayerW'(lay);
    it.row_sel    = lcs_pkg::RowW'(row);
    it.pixel_byte = pix;
    return it;
  endfunction

  function automatic lcs_pkg::item_t scan_tick();
    lcs_pkg::item_t it;
    it = lcs_pkg::item_t'(ItemW'($urandom));
    it.kind = lcs_pkg::KindTick;
    return it;
  endfunction

  // frame extremes under reset brightness, including the wrap to layer 0
  task automatic test_frame_patterns();
    send_item(frame_write(1, 0, 8'h80));
    send_item(frame_write(1, 7, 8'h01));
    send_item(frame_write(7, 3, 8'hFF));
    send_item(frame_write(0, 0, 8'hA5));
    send_item(frame_write(0, 0, 8'h5A));
    repeat (lcs_pkg::NumLayers) send_item(scan_tick());
  endtask

  // dark layers and full brightness on some layers
  task automatic test_brightness_extremes();
    program_brightness({8'd254, 8'd7, 8'd0, 8'd255, 8'd128, 8'd1, 8'd255, 8'd0});
    repeat (lcs_pkg::NumLayers) send_item(scan_tick());
  endtask

  // random frame writes and ticks under a random brightness setting
  task automatic test_random_traffic(input int unsigned n_items, input int unsigned pct);
    logic [lcs_pkg::NumLayers-1:0][lcs_pkg::ByteW-1:0] lvls;
    lcs_pkg::item_t it;
    for (int k = 0; k < lcs_pkg::NumLayers; k++) begin
      case ($urandom_range(3))
        0: lvls[k] = 8'd0;
        1: lvls[k] = 8'd255;
        default: lvls[k] = lcs_pkg::ByteW'($urandom);
      endcase
    end
    program_brightness(lvls);
    gap_pct = pct;
    repeat (n_items) begin
      it = lcs_pkg::item_t'(ItemW'($urandom));
      it.kind = ($urandom_range(99) < TickPct) ? lcs_pkg::KindTick : lcs_pkg::KindWrite;
      send_item(it);
    end
    gap_pct = 0;
  endtask

  initial begin
    rst_ni         <= 1'b0;
    start          <= 1'b0;
    item_i         <= '0;
    cfg_valid_i    <= 1'b0;
    cfg_index_i    <= '0;
    cfg_data_i     <= '0;
    mismatch_count = 0;
    gap_pct        = 0;
    quiet_cycles   = 0;
    for (int k = 0; k < lcs_pkg::NumLayers; k++) bright_mdl[k] = lcs_pkg::BrightReset[k];
    for (int k = 0; k < FrameDepth; k++) frame_mdl[k] = '0;
    layer_mdl = '0;
    tick_mdl  = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_frame_patterns();
    test_brightness_extremes();
    test_random_traffic(50, 0);
    test_random_traffic(50, 56);
    // the receiver cannot stall; this phase runs without sender gaps
    test_random_traffic(50, 0);
    test_random_traffic(50, 35);

    settle_idle();
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
